FILE: src/assert_macros.svh
// Assertion macros shared by the rotation pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define VROT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression must never be true outside reset
`define VROT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define VROT_ASSERT(name, clk, rst, prop, msg)
`define VROT_NEVER(name, clk, rst, expr, msg)
`endif
`endif

FILE: src/vrot_pkg.sv
// Types, constants and tables of the vector axis rotation pipeline
package vrot_pkg;

   localparam int DEF_ROTATION_STAGES = 18;
   localparam int TABLE_LEN           = 28;

   localparam int COORD_W  = 32;
   localparam int ANGLE_W  = 24;
   localparam int AXIS_W   = 2;
   localparam int CORDIC_W = 33;
   localparam int TURN_W   = ANGLE_W + 1;
   localparam int FOLD_W   = 15;
   localparam int REDUCE_STEPS = 8;

   // Angles in degrees with 8 fraction bits
   localparam logic [TURN_W-1:0] FULL_TURN    = 25'd92160;
   localparam logic [TURN_W-1:0] HALF_TURN    = 25'd46080;
   localparam logic [TURN_W-1:0] QUARTER_TURN = 25'd23040;
   // 92 full turns: lifts any input angle above zero without changing it mod 360
   localparam logic [TURN_W-1:0] TURN_BIAS    = 25'd8478720;

   // pi/180 in Q38, product shifted down by 16 gives Q30 radians
   localparam int D2R_W     = 33;
   localparam int D2R_SHIFT = 16;
   localparam int D2R_PROD_W = FOLD_W + D2R_W;
   localparam logic [D2R_W-1:0] DEG2RAD_K = 33'd4797524517;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

   localparam int UNIT_SHIFT = 30;
   localparam int ATAN_W     = 30;

   localparam logic [ATAN_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
      30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
      30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
      30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
      30'h0000001F, 30'h0000000F, 30'h00000008
   };

   typedef enum logic [AXIS_W-1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef struct packed {
      axis_type                   axis;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  z;
   } vec_type;

   typedef struct packed {
      vec_type                    vec;
      logic [TURN_W-1:0]          turn;
   } reduce_type;

   typedef struct packed {
      vec_type                    vec;
      logic                       neg_cos;
      logic                       neg_both;
      logic [FOLD_W-1:0]          fold;
   } fold_type;

   typedef struct packed {
      vec_type                    vec;
      logic                       neg_cos;
      logic                       neg_both;
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
   } cordic_type;

endpackage

FILE: src/vrot_if.sv
// Request and response channel interfaces of the rotation pipeline
interface vrot_req_if import vrot_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [AXIS_W-1:0]         axis_sel;
   logic signed [ANGLE_W-1:0] angle_deg;
   logic signed [COORD_W-1:0] in_x;
   logic signed [COORD_W-1:0] in_y;
   logic signed [COORD_W-1:0] in_z;

   modport source (output valid, axis_sel, angle_deg, in_x, in_y, in_z, input ready);
   modport sink   (input valid, axis_sel, angle_deg, in_x, in_y, in_z, output ready);
endinterface

interface vrot_rsp_if import vrot_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic signed [COORD_W-1:0] out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

FILE: src/vrot_reduce_cell.sv
// One compare-and-subtract cell of the modulo 360 angle reduction
`include "assert_macros.svh"
module vrot_reduce_cell import vrot_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  reduce_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output reduce_type out_data
);

   localparam logic [TURN_W-1:0] STEP_MULT = FULL_TURN << STEP;
   // the first cell also lifts negative angles into range
   localparam logic [TURN_W-1:0] STEP_BIAS = (STEP == REDUCE_STEPS - 1) ? TURN_BIAS : '0;

   logic              valid_ff;
   reduce_type        data_ff;
   reduce_type        data_in;
   logic [TURN_W-1:0] biased;

   always_comb begin
      biased  = in_data.turn + STEP_BIAS;
      data_in = in_data;
      data_in.turn = (biased >= STEP_MULT) ? (biased - STEP_MULT) : biased;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   `VROT_ASSERT(a_turn_below_step, clock, reset, valid_ff |-> (data_ff.turn < STEP_MULT), "reduced angle not below step multiple")

endmodule

FILE: src/vrot_angle.sv
// Quadrant fold and degree to radian conversion feeding the CORDIC chain
`include "assert_macros.svh"
module vrot_angle import vrot_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  reduce_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output cordic_type out_data
);

   logic              fold_valid_ff;
   fold_type          fold_ff;
   fold_type          fold_in;
   logic              fold_ready;
   logic [TURN_W-1:0] half_off;
   logic [TURN_W-1:0] folded;

   logic                  rad_valid_ff;
   cordic_type            rad_ff;
   cordic_type            rad_in;
   logic                  rad_ready;
   logic [D2R_PROD_W-1:0] prod;
   logic [D2R_PROD_W-1:0] rounded;

   // fold the angle into the first quadrant and note the sign changes
   always_comb begin
      fold_in.vec      = in_data.vec;
      fold_in.neg_both = (in_data.turn >= HALF_TURN);
      half_off         = fold_in.neg_both ? (in_data.turn - HALF_TURN) : in_data.turn;
      fold_in.neg_cos  = (half_off > QUARTER_TURN);
      folded           = fold_in.neg_cos ? (HALF_TURN - half_off) : half_off;
      fold_in.fold     = folded[FOLD_W-1:0];
   end

   always_comb begin
      prod    = D2R_PROD_W'(fold_ff.fold) * D2R_PROD_W'(DEG2RAD_K);
      rounded = prod + (D2R_PROD_W'(1) << (D2R_SHIFT - 1));
      rad_in.vec      = fold_ff.vec;
      rad_in.neg_cos  = fold_ff.neg_cos;
      rad_in.neg_both = fold_ff.neg_both;
      rad_in.x        = CORDIC_GAIN;
      rad_in.y        = '0;
      rad_in.z        = CORDIC_W'(rounded[D2R_PROD_W-1:D2R_SHIFT]);
   end

   assign rad_ready  = !rad_valid_ff || out_ready;
   assign fold_ready = !fold_valid_ff || rad_ready;
   assign in_ready   = fold_ready;
   assign out_valid  = rad_valid_ff;
   assign out_data   = rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
         rad_valid_ff  <= 1'b0;
      end else begin
         if (fold_ready) begin
            fold_valid_ff <= in_valid;
         end
         if (rad_ready) begin
            rad_valid_ff <= fold_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && fold_ready) begin
         fold_ff <= fold_in;
      end
      if (fold_valid_ff && rad_ready) begin
         rad_ff <= rad_in;
      end
   end

   `VROT_ASSERT(a_fold_in_quadrant, clock, reset, fold_valid_ff |-> (TURN_W'(fold_ff.fold) <= QUARTER_TURN), "folded angle beyond a quarter turn")

endmodule

FILE: src/vrot_cordic_cell.sv
// One rotation stage of the CORDIC sine and cosine chain
module vrot_cordic_cell import vrot_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  cordic_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output cordic_type out_data
);

   localparam logic signed [CORDIC_W-1:0] ATAN_STEP = CORDIC_W'(ATAN_TABLE[SHIFT]);

   logic                       valid_ff;
   cordic_type                 data_ff;
   cordic_type                 data_in;
   logic signed [CORDIC_W-1:0] cur_x;
   logic signed [CORDIC_W-1:0] cur_y;
   logic signed [CORDIC_W-1:0] dx;
   logic signed [CORDIC_W-1:0] dy;

   always_comb begin
      cur_x   = in_data.x;
      cur_y   = in_data.y;
      dx      = cur_y >>> SHIFT;
      dy      = cur_x >>> SHIFT;
      data_in = in_data;
      // step towards zero residual angle; zero counts as positive
      if (!in_data.z[CORDIC_W-1]) begin
         data_in.x = cur_x - dx;
         data_in.y = cur_y + dy;
         data_in.z = in_data.z - ATAN_STEP;
      end else begin
         data_in.x = cur_x + dx;
         data_in.y = cur_y - dy;
         data_in.z = in_data.z + ATAN_STEP;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: src/vrot_rotate.sv
// Quadrant signs, rotation products, rounding, saturation and output register
`include "assert_macros.svh"
module vrot_rotate import vrot_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  cordic_type  in_data,
   vrot_rsp_if.source  rsp_bus
);

   localparam int PROD_W = CORDIC_W + COORD_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int QUO_W  = SUM_W - UNIT_SHIFT;

   // stage 0: signed cosine and sine, plane coordinates
   logic                       v0_ff;
   logic                       r0;
   vec_type                    vec0_ff;
   logic signed [CORDIC_W-1:0] cos0_ff, sin0_ff, cos0_in, sin0_in;
   logic signed [COORD_W-1:0]  a0_ff, b0_ff, a0_in, b0_in;

   // stage 1: products
   logic                       v1_ff;
   logic                       r1;
   vec_type                    vec1_ff;
   logic signed [PROD_W-1:0]   p_ca_ff, p_sb_ff, p_sa_ff, p_cb_ff;

   // stage 2: output register
   logic                       v2_ff;
   logic                       r2;
   logic signed [COORD_W-1:0]  out_x_ff, out_y_ff, out_z_ff;
   logic signed [COORD_W-1:0]  out_x_in, out_y_in, out_z_in;
   logic signed [COORD_W-1:0]  new_a, new_b;

   function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [SUM_W-1:0] acc);
      logic signed [SUM_W-1:0] biased;
      logic signed [QUO_W-1:0] quo;
      logic                    all_ones;
      logic                    any_ones;
      biased   = acc + (SUM_W'(1) << (UNIT_SHIFT - 1));
      quo      = biased[SUM_W-1:UNIT_SHIFT];
      all_ones = &quo[QUO_W-2:COORD_W-1];
      any_ones = |quo[QUO_W-2:COORD_W-1];
      if (!quo[QUO_W-1] && any_ones) begin
         round_sat = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (quo[QUO_W-1] && !all_ones) begin
         round_sat = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         round_sat = quo[COORD_W-1:0];
      end
   endfunction

   always_comb begin
      cos0_in = (in_data.neg_cos ^ in_data.neg_both) ? -in_data.x : in_data.x;
      sin0_in = in_data.neg_both ? -in_data.y : in_data.y;
      // pick the plane: new_a = c*a - s*b, new_b = s*a + c*b
      case (in_data.vec.axis)
         AXIS_X: begin
            a0_in = in_data.vec.y;
            b0_in = in_data.vec.z;
         end
         AXIS_Y: begin
            a0_in = in_data.vec.z;
            b0_in = in_data.vec.x;
         end
         default: begin
            a0_in = in_data.vec.x;
            b0_in = in_data.vec.y;
         end
      endcase
   end

   always_comb begin
      new_a = round_sat(SUM_W'(p_ca_ff) - SUM_W'(p_sb_ff));
      new_b = round_sat(SUM_W'(p_sa_ff) + SUM_W'(p_cb_ff));
      case (vec1_ff.axis)
         AXIS_X: begin
            out_x_in = vec1_ff.x;
            out_y_in = new_a;
            out_z_in = new_b;
         end
         AXIS_Y: begin
            out_x_in = new_b;
            out_y_in = vec1_ff.y;
            out_z_in = new_a;
         end
         AXIS_Z: begin
            out_x_in = new_a;
            out_y_in = new_b;
            out_z_in = vec1_ff.z;
         end
         AXIS_NONE: begin
            out_x_in = vec1_ff.x;
            out_y_in = vec1_ff.y;
            out_z_in = vec1_ff.z;
         end
         default: begin
            out_x_in = vec1_ff.x;
            out_y_in = vec1_ff.y;
            out_z_in = vec1_ff.z;
         end
      endcase
   end

   assign r2       = !v2_ff || rsp_bus.ready;
   assign r1       = !v1_ff || r2;
   assign r0       = !v0_ff || r1;
   assign in_ready = r0;

   assign rsp_bus.valid = v2_ff;
   assign rsp_bus.out_x = out_x_ff;
   assign rsp_bus.out_y = out_y_ff;
   assign rsp_bus.out_z = out_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (r0) begin
            v0_ff <= in_valid;
         end
         if (r1) begin
            v1_ff <= v0_ff;
         end
         if (r2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && r0) begin
         vec0_ff <= in_data.vec;
         cos0_ff <= cos0_in;
         sin0_ff <= sin0_in;
         a0_ff   <= a0_in;
         b0_ff   <= b0_in;
      end
      if (v0_ff && r1) begin
         vec1_ff <= vec0_ff;
         p_ca_ff <= cos0_ff * a0_ff;
         p_sb_ff <= sin0_ff * b0_ff;
         p_sa_ff <= sin0_ff * a0_ff;
         p_cb_ff <= cos0_ff * b0_ff;
      end
      if (v1_ff && r2) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= out_z_in;
      end
   end

   `VROT_ASSERT(a_cordic_in_range, clock, reset, in_valid |-> ((in_data.x[CORDIC_W-1] == in_data.x[CORDIC_W-2]) && (in_data.y[CORDIC_W-1] == in_data.y[CORDIC_W-2])), "CORDIC result outside the signed 32-bit range")

endmodule

FILE: src/vector_axis_rotate_core.sv
// Top level: rotates a Q16.16 vector about the x, y or z axis by an angle in degrees
//
// Request channel req_bus carries axis_sel, angle_deg (degrees, 8 fraction bits)
// and in_x, in_y, in_z; response channel rsp_bus carries out_x, out_y, out_z.
// A beat moves when valid and ready are both high at a rising clock edge.
// Axis code 3 returns the vector unchanged; the coordinate on the rotation axis
// is always copied unchanged, the other two are rounded and saturated.
// The stages in order: eight modulo-360 reduction cells,
// fold and degree-to-radian stages, one CORDIC cell per stage, then signs,
// products and the rounding/output register. Every cell holds one beat, so while
// the receiver does not stall, one request is taken and one response given per clock cycle.
// When the receiver stalls, the response holds in the output register and the
// cells behind it keep filling; req_bus.ready drops only once every cell holds
// a beat. Synchronous reset empties the pipeline; no beats are in flight after.
module vector_axis_rotate_core import vrot_pkg::*; #(
   parameter int ROTATION_STAGES = DEF_ROTATION_STAGES
) (
   input  logic       clock,
   input  logic       reset,
   vrot_req_if.sink   req_bus,
   vrot_rsp_if.source rsp_bus
);

   reduce_type red_d [REDUCE_STEPS+1];
   logic       red_v [REDUCE_STEPS+1];
   logic       red_r [REDUCE_STEPS+1];

   cordic_type cor_d [ROTATION_STAGES+1];
   logic       cor_v [ROTATION_STAGES+1];
   logic       cor_r [ROTATION_STAGES+1];

   always_comb begin
      red_d[0].vec.axis = axis_type'(req_bus.axis_sel);
      red_d[0].vec.x    = req_bus.in_x;
      red_d[0].vec.y    = req_bus.in_y;
      red_d[0].vec.z    = req_bus.in_z;
      red_d[0].turn     = TURN_W'(req_bus.angle_deg);
   end

   assign red_v[0]      = req_bus.valid;
   assign req_bus.ready = red_r[0];

   for (genvar g = 0; g < REDUCE_STEPS; g++) begin : g_reduce
      vrot_reduce_cell #(
         .STEP (REDUCE_STEPS - 1 - g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (red_v[g]),
         .in_ready  (red_r[g]),
         .in_data   (red_d[g]),
         .out_valid (red_v[g+1]),
         .out_ready (red_r[g+1]),
         .out_data  (red_d[g+1])
      );
   end

   vrot_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_v[REDUCE_STEPS]),
      .in_ready  (red_r[REDUCE_STEPS]),
      .in_data   (red_d[REDUCE_STEPS]),
      .out_valid (cor_v[0]),
      .out_ready (cor_r[0]),
      .out_data  (cor_d[0])
   );

   for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cordic
      vrot_cordic_cell #(
         .SHIFT (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cor_v[g]),
         .in_ready  (cor_r[g]),
         .in_data   (cor_d[g]),
         .out_valid (cor_v[g+1]),
         .out_ready (cor_r[g+1]),
         .out_data  (cor_d[g+1])
      );
   end

   vrot_rotate u_rotate (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cor_v[ROTATION_STAGES]),
      .in_ready (cor_r[ROTATION_STAGES]),
      .in_data  (cor_d[ROTATION_STAGES]),
      .rsp_bus  (rsp_bus)
   );

   `VROT_ASSERT(a_ready_when_drained, clock, reset, !rsp_bus.valid |-> req_bus.ready, "request stalled with an empty output register")
   `VROT_ASSERT(a_accept_enters, clock, reset, (req_bus.valid && req_bus.ready) |=> red_v[1], "accepted beat missing from the first cell")

endmodule

FILE: dv/vrot_rotation_checker.sv
// Scoreboard for the axis rotation core: predicts each rotated vector and compares responses
module vrot_rotation_checker import vrot_pkg::*; #(
   parameter int ROTATION_STAGES = DEF_ROTATION_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   vrot_req_if         req_mon,
   vrot_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     ARCTAN_LEN     = 28;
   localparam longint TURN_Q8        = 92160;
   localparam longint HALF_TURN_Q8   = 46080;
   localparam longint RIGHT_ANGLE_Q8 = 23040;
   localparam longint DEG_TO_RAD_Q38 = 64'd4797524517;
   localparam longint UNIT_GAIN_Q30  = 652032874;
   localparam longint COORD_MAX      = 64'sd2147483647;
   localparam longint COORD_MIN      = -64'sd2147483648;

   localparam longint ARCTAN_Q30 [ARCTAN_LEN] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000008
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } coords_type;

   coords_type  rotated_q [$];
   int unsigned mismatches = 0;

   // Q30 product sum back to Q16.16, rounding half up, then clamp
   function automatic logic signed [COORD_W-1:0] round_saturate(longint acc);
      longint r;
      r = (acc + (longint'(1) << 29)) >>> 30;
      if (r > COORD_MAX) return COORD_MAX[COORD_W-1:0];
      if (r < COORD_MIN) return COORD_MIN[COORD_W-1:0];
      return r[COORD_W-1:0];
   endfunction

   function automatic coords_type predict_rotation(axis_type axis,
                                                   logic signed [ANGLE_W-1:0] angle,
                                                   coords_type v);
      longint     turn, theta, cosv, sinv, dx, dy, px, py, pz;
      bit         flip_cos, flip_both;
      int         stage;
      coords_type res;
      res = v;
      if (axis == AXIS_NONE) return res;

      // reduce to [0, 360) and fold into the first quadrant
      turn = longint'(angle) % TURN_Q8;
      if (turn < 0) turn += TURN_Q8;
      flip_both = (turn >= HALF_TURN_Q8);
      if (flip_both) turn -= HALF_TURN_Q8;
      flip_cos = (turn > RIGHT_ANGLE_Q8);
      if (flip_cos) turn = HALF_TURN_Q8 - turn;
      theta = (turn * DEG_TO_RAD_Q38 + (longint'(1) << 15)) >>> 16;

      cosv = UNIT_GAIN_Q30;
      sinv = 0;
      for (stage = 0; stage < ROTATION_STAGES && stage < ARCTAN_LEN; stage++) begin
         dx = sinv >>> stage;
         dy = cosv >>> stage;
         if (theta >= 0) begin
            cosv  -= dx;
            sinv  += dy;
            theta -= ARCTAN_Q30[stage];
         end else begin
            cosv  += dx;
            sinv  -= dy;
            theta += ARCTAN_Q30[stage];
         end
      end
      if (flip_cos) cosv = -cosv;
      if (flip_both) begin
         cosv = -cosv;
         sinv = -sinv;
      end

      px = longint'($signed(v.x));
      py = longint'($signed(v.y));
      pz = longint'($signed(v.z));
      case (axis)
         AXIS_X: begin
            res.y = round_saturate(cosv * py - sinv * pz);
            res.z = round_saturate(sinv * py + cosv * pz);
         end
         AXIS_Y: begin
            res.x = round_saturate(cosv * px + sinv * pz);
            res.z = round_saturate(cosv * pz - sinv * px);
         end
         default: begin
            res.x = round_saturate(cosv * px - sinv * py);
            res.y = round_saturate(sinv * px + cosv * py);
         end
      endcase
      return res;
   endfunction

   task automatic report_failure(string msg);
      $display("[%0t] rotation check: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string field, logic signed [COORD_W-1:0] got,
                              logic signed [COORD_W-1:0] want);
      if (got !== want)
         report_failure($sformatf("%s got %0d expected %0d", field, got, want));
   endtask

   always @(posedge clock) begin
      coords_type got, want;
      if (reset) begin
         rotated_q.delete();
      end else begin
         // retire the response before queueing a new request taken on the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.out_x, rsp_mon.out_y, rsp_mon.out_z};
            if (rotated_q.size() == 0) begin
               report_failure($sformatf("response beat with nothing outstanding: %h %h %h",
                                        got.x, got.y, got.z));
            end else begin
               want = rotated_q.pop_front();
               check_field("out_x", got.x, want.x);
               check_field("out_y", got.y, want.y);
               check_field("out_z", got.z, want.z);
            end
         end
         if (req_mon.valid && req_mon.ready)
            rotated_q.push_back(predict_rotation(
               axis_type'(req_mon.axis_sel), req_mon.angle_deg,
               coords_type'{req_mon.in_x, req_mon.in_y, req_mon.in_z}));
      end
      fail_count    <= mismatches;
      pending_count <= rotated_q.size();
   end

endmodule

FILE: dv/tb_vector_axis_rotate_core.sv
// Testbench top for the axis rotation core: clock, reset, request and response traffic, verdict
module tb_vector_axis_rotate_core import vrot_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROT_STAGES      = DEF_ROTATION_STAGES;
   localparam int PIPE_LATENCY    = ROT_STAGES + 13;
   localparam int RANDOM_ITEMS    = 1150;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER  = 300;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int DEG             = 256;
   localparam int ONE             = 65536;

   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFFFFFF;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;
   localparam logic signed [ANGLE_W-1:0] A_MAX = 24'sh7FFFFF;
   localparam logic signed [ANGLE_W-1:0] A_MIN = 24'sh800000;

   typedef struct {
      axis_type                  axis;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } request_type;

   logic        clock;
   logic        reset;
   int unsigned items_sent  = 0;
   int unsigned cycle_count = 0;
   bit          quiet_phase = 1'b0;
   int unsigned fail_count;
   int unsigned pending_count;

   vrot_req_if req_bus ();
   vrot_rsp_if rsp_bus ();

   vector_axis_rotate_core #(.ROTATION_STAGES(ROT_STAGES)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   vrot_rotation_checker #(.ROTATION_STAGES(ROT_STAGES)) rotation_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned next_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6, 7:       return int'($urandom_range(0, 2 * ONE * 16)) - ONE * 16;
         8: begin
            case ($urandom_range(0, 3))
               0:       return C_MAX;
               1:       return C_MIN;
               2:       return 0;
               default: return -1;
            endcase
         end
         default:       return $urandom_range(0, 1) ? C_MAX - $urandom_range(0, 65535)
                                                    : C_MIN + $urandom_range(0, 65535);
      endcase
   endfunction

   // hold the beat until taken, then idle for a random gap unless in a quiet stretch
   task automatic send_request(request_type rq);
      int unsigned gap;
      req_bus.valid     <= 1'b1;
      req_bus.axis_sel  <= rq.axis;
      req_bus.angle_deg <= rq.angle;
      req_bus.in_x      <= rq.x;
      req_bus.in_y      <= rq.y;
      req_bus.in_z      <= rq.z;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      @(negedge clock);
      gap = quiet_phase ? 0 : next_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // receiver: random stalls, one long hold-off to back the pipeline up
   initial begin
      int unsigned gap;
      bit          held;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (!held && items_sent >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         gap = quiet_phase ? 0 : next_gap();
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   initial begin
      request_type opening [$];
      request_type rq;
      int          k;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.axis_sel  <= AXIS_X;
      req_bus.angle_deg <= '0;
      req_bus.in_x      <= '0;
      req_bus.in_y      <= '0;
      req_bus.in_z      <= '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      opening = '{
         '{AXIS_X,    ANGLE_W'(0),             ONE,      2 * ONE,  3 * ONE},
         '{AXIS_Y,    ANGLE_W'(90 * DEG),      ONE,      2 * ONE,  -ONE},
         '{AXIS_Z,    ANGLE_W'(180 * DEG),     3 * ONE,  -5 * ONE, 7 * ONE},
         '{AXIS_Z,    ANGLE_W'(270 * DEG),     -ONE,     ONE / 2,  4 * ONE},
         '{AXIS_X,    ANGLE_W'(360 * DEG),     ONE,      -3 * ONE, 2 * ONE},
         '{AXIS_Y,    ANGLE_W'(-90 * DEG),     2 * ONE,  ONE,      ONE},
         '{AXIS_Z,    A_MAX,                   1000000,  -2000000, 5},
         '{AXIS_X,    A_MIN,                   -7,       123456,   -654321},
         '{AXIS_Z,    ANGLE_W'(45 * DEG),      C_MAX,    C_MAX,    C_MIN},
         '{AXIS_Z,    ANGLE_W'(45 * DEG),      C_MIN,    C_MIN,    C_MAX},
         '{AXIS_X,    ANGLE_W'(45 * DEG),      C_MIN,    C_MAX,    C_MAX},
         '{AXIS_Y,    ANGLE_W'(135 * DEG),     C_MIN,    C_MAX,    C_MIN},
         '{AXIS_NONE, ANGLE_W'(12345),         C_MAX,    C_MIN,    -1},
         '{AXIS_NONE, A_MIN,                   0,        -1,       C_MAX},
         '{AXIS_Z,    ANGLE_W'(90 * DEG + 1),  ONE,      ONE,      0},
         '{AXIS_Y,    ANGLE_W'(180 * DEG - 1), ONE,      -ONE,     ONE},
         '{AXIS_X,    ANGLE_W'(-1),            0,        C_MAX,    C_MIN},
         '{AXIS_Z,    ANGLE_W'(1),             C_MAX,    0,        C_MIN},
         '{AXIS_Y,    ANGLE_W'(-360 * DEG),    5 * ONE,  C_MIN,    -5 * ONE},
         '{AXIS_X,    ANGLE_W'(90 * DEG),      C_MAX,    ONE,      ONE},
         '{AXIS_Z,    ANGLE_W'(30 * DEG),      ONE,      ONE,      C_MIN}
      };
      foreach (opening[i]) send_request(opening[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_phase = ((n / 100) % 3 == 1);
         rq.axis = axis_type'(AXIS_W'($urandom_range(0, 3)));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: rq.angle = ANGLE_W'($urandom);
            4, 5, 6: begin
               // land on or next to a quadrant boundary
               k = int'($urandom_range(0, 32)) - 16;
               rq.angle = ANGLE_W'(k * 90 * DEG + int'($urandom_range(0, 4)) - 2);
            end
            default: rq.angle = ANGLE_W'(int'($urandom_range(0, 1440 * DEG)) - 720 * DEG);
         endcase
         rq.x = random_coord();
         rq.y = random_coord();
         rq.z = random_coord();
         send_request(rq);
      end
      quiet_phase = 1'b0;
      req_bus.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 16) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
